// ===== rtl/pol_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional ordered list package
// Shared types, codes and default sizes for the positional ordered list.
// ----------------------------------------------------------------------------
package pol_pkg;

    // Default sizes handed to the top level.
    localparam int DEPTH_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Request operation codes. Code 3 carries no meaning.
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_READ   = 2'd2
    } func_t;

    // Result status codes.
    typedef enum logic [2:0] {
        STATUS_OK      = 3'd0,
        STATUS_INVALID = 3'd1,
        STATUS_BEYOND  = 3'd2,
        STATUS_EMPTY   = 3'd3,
        STATUS_FULL    = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [0:0] {
        ST_IDLE   = 1'b0,
        ST_GATHER = 1'b1
    } state_t;

    // Update strobes broadcast to every cell.
    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } cell_ctrl_t;

endpackage

// ===== rtl/pol_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional ordered list cell
// Holds one list entry. On insert or remove it takes its value from the
// new word or from a neighbour; it also presents its entry when selected.
// ----------------------------------------------------------------------------
module pol_cell #(
    parameter int IDX         = 0,
    parameter int IDX_W       = 6,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  pol_pkg::cell_ctrl_t    ctrl,
    input  logic [IDX_W-1:0]       upd_idx,
    input  logic [IDX_W-1:0]       rd_idx,
    input  logic [VALUE_WIDTH-1:0] new_value,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic [VALUE_WIDTH-1:0] right_value,
    output logic [VALUE_WIDTH-1:0] value,
    output logic [VALUE_WIDTH-1:0] rd_leaf
);
    import pol_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic [VALUE_WIDTH-1:0] rd_reg;
    logic [VALUE_WIDTH-1:0] rd_next;

    // Shift rule: insert moves later entries back, remove pulls them forward.
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins_en)
        begin
            if (upd_idx == MY_IDX)
                value_next = new_value;
            else if (upd_idx < MY_IDX)
                value_next = left_value;
        end
        else if (ctrl.rem_en && (upd_idx <= MY_IDX))
        begin
            value_next = right_value;
        end
    end

    // Only the selected cell drives a non-zero word into the gather tree.
    always_comb
    begin
        rd_next = (rd_idx == MY_IDX) ? value_reg : '0;
    end

    // Entry storage carries no reset; it is read only once written.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        rd_reg    <= rd_next;
    end

    assign value   = value_reg;
    assign rd_leaf = rd_reg;

endmodule

// ===== rtl/pol_gather.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional ordered list gather tree
// Registered binary OR tree that collects the one selected cell word.
// Every tree level is registered, from the leaves up to the root.
// ----------------------------------------------------------------------------
module pol_gather #(
    parameter int DEPTH       = 64,
    parameter int IDX_W       = 6,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic [VALUE_WIDTH-1:0] leaf [DEPTH],
    output logic [VALUE_WIDTH-1:0] root
);
    import pol_pkg::*;

    localparam int N_LEAF = 2 ** IDX_W;
    localparam int N_NODE = 2 * N_LEAF - 1;

    // Heap layout: internal nodes first, then the padded leaves.
    logic [VALUE_WIDTH-1:0] node_all [N_NODE];
    logic [VALUE_WIDTH-1:0] node_reg [N_LEAF-1];

    genvar g;
    generate
        for (g = 0; g < N_LEAF; g++)
        begin : g_leaf
            if (g < DEPTH)
            begin : g_used
                assign node_all[N_LEAF-1+g] = leaf[g];
            end
            else
            begin : g_pad
                assign node_all[N_LEAF-1+g] = '0;
            end
        end

        // Each internal node registers the OR of its two children.
        for (g = 0; g < N_LEAF - 1; g++)
        begin : g_node
            assign node_all[g] = node_reg[g];
            always_ff @(posedge clk)
            begin
                node_reg[g] <= node_all[2*g+1] | node_all[2*g+2];
            end
        end
    endgenerate

    assign root = node_all[0];

endmodule

// ===== rtl/positional_ordered_list_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional ordered list
// Ordered list of up to DEPTH signed words with insert, remove and read
// at a 1-based position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
// - Request channel (in_valid / in_ready) carries func, position and
//   item_value; one word is accepted at a time, when the block is idle.
// - Result channel (out_valid / out_ready) returns one word per request:
//   status and read_value (zero unless a read succeeds).
// - Inserts and removes shift the cells at and after the position in the
//   cycle of acceptance. Every result then passes the request index
//   register, the cell select register, each level of the registered OR
//   tree and the output register before it is valid.
// - Requests do not overlap: the next one is taken only once the previous
//   result has been loaded into the output register.
// - A finished result sits in the output register; a new request is taken
//   while it waits. If the receiver still stalls when the next result is
//   ready, the block holds that result in the tree and accepts nothing more.
// - Reset empties the list and drops any pending result; entry storage is
//   not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module positional_ordered_list_top #(
    parameter int DEPTH       = pol_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = pol_pkg::VALUE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [6:0]         position,
    input  logic signed [31:0] item_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] read_value
);
    import pol_pkg::*;

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = ((CNT_W > 7) ? CNT_W : 7) + 1;
    localparam int WAIT_W  = $clog2(IDX_W + 2);
    localparam logic [WAIT_W-1:0] WAIT_LOAD = WAIT_W'(IDX_W + 1);
    localparam logic [CMP_W-1:0]  DEPTH_CMP = CMP_W'(DEPTH);

    state_t                 state_reg;
    state_t                 state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [WAIT_W-1:0]      wait_reg;
    logic [WAIT_W-1:0]      wait_next;
    logic [IDX_W-1:0]       rd_idx_reg;
    status_t                pend_status_reg;
    logic                   func_read_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    status_t                out_status_reg;
    logic [31:0]            out_value_reg;

    logic                   accept;
    logic                   result_load;
    status_t                req_status;
    cell_ctrl_t             ctrl;
    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       cnt_ext;
    logic [CMP_W-1:0]       pos_m1;
    logic [IDX_W-1:0]       upd_idx;
    logic [63:0]            item_ext;
    logic [VALUE_WIDTH-1:0] new_value;
    logic [VALUE_WIDTH-1:0] root;
    logic [VALUE_WIDTH+31:0] root_ext;

    logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_leaf    [DEPTH];

    assign accept   = in_valid && in_ready;
    assign pos_ext  = CMP_W'(position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_m1   = pos_ext - CMP_W'(1);
    assign upd_idx  = pos_m1[IDX_W-1:0];
    assign item_ext = {{32{item_value[31]}}, item_value};
    assign new_value = item_ext[VALUE_WIDTH-1:0];

    // Request decode: status and shift strobes from the live count.
    always_comb
    begin
        req_status  = STATUS_INVALID;
        ctrl.ins_en = 1'b0;
        ctrl.rem_en = 1'b0;
        if (position != 7'd0)
        begin
            unique case (func)
                FUNC_INSERT:
                begin
                    if (pos_ext > cnt_ext + CMP_W'(1))
                        req_status = STATUS_BEYOND;
                    else if (cnt_ext == DEPTH_CMP)
                        req_status = STATUS_FULL;
                    else
                    begin
                        req_status  = STATUS_OK;
                        ctrl.ins_en = accept;
                    end
                end
                FUNC_REMOVE:
                begin
                    if (count_reg == '0)
                        req_status = STATUS_EMPTY;
                    else if (pos_ext > cnt_ext)
                        req_status = STATUS_BEYOND;
                    else
                    begin
                        req_status  = STATUS_OK;
                        ctrl.rem_en = accept;
                    end
                end
                FUNC_READ:
                begin
                    if (pos_ext > cnt_ext)
                        req_status = STATUS_BEYOND;
                    else
                        req_status = STATUS_OK;
                end
                default:
                begin
                    req_status = STATUS_INVALID;
                end
            endcase
        end
    end

    // Entry count follows the accepted inserts and removes.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins_en)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.rem_en)
            count_next = count_reg - CNT_W'(1);
    end

    // Result load: the tree has settled and the output register is free.
    assign result_load = (state_reg == ST_GATHER) && (wait_reg == '0)
                         && (!out_valid_reg || out_ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_GATHER;
            end
            ST_GATHER:
            begin
                if (result_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs: ready, gather countdown and output valid.
    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg;
        if (accept)
            wait_next = WAIT_LOAD;
        else if ((state_reg == ST_GATHER) && (wait_reg != '0))
            wait_next = wait_reg - WAIT_W'(1);
        if (result_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload registers.
    assign root_ext = {{32{root[VALUE_WIDTH-1]}}, root};

    // A read result is the only one that carries a value.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_idx_reg      <= upd_idx;
            pend_status_reg <= req_status;
            func_read_reg   <= (func == FUNC_READ);
        end
        if (result_load)
        begin
            out_status_reg <= pend_status_reg;
            if (func_read_reg && (pend_status_reg == STATUS_OK))
                out_value_reg <= root_ext[31:0];
            else
                out_value_reg <= '0;
        end
    end

    // Row of cells, each linked to both neighbours.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] left_w;
            logic [VALUE_WIDTH-1:0] right_w;

            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = cell_value[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = cell_value[g+1];
            end

            pol_cell #(
                .IDX         (g),
                .IDX_W       (IDX_W),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .upd_idx     (upd_idx),
                .rd_idx      (rd_idx_reg),
                .new_value   (new_value),
                .left_value  (left_w),
                .right_value (right_w),
                .value       (cell_value[g]),
                .rd_leaf     (rd_leaf[g])
            );
        end
    endgenerate

    // Registered OR tree bringing the selected entry out.
    pol_gather #(
        .DEPTH       (DEPTH),
        .IDX_W       (IDX_W),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_gather (
        .clk   (clk),
        .leaf  (rd_leaf),
        .root  (root)
    );

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign read_value = out_value_reg;

endmodule
